// ----- src/oale_pkg.sv -----
package oale_pkg;

  // Default sizes of the list storage.
  localparam int DEPTH_DEF        = 32;
  localparam int KEY_BITS_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed widths of the fields on the ports.
  localparam int MODE_W = 3;
  localparam int POS_W  = 5;
  localparam int KEY_W  = 64;
  localparam int PAY_W  = 32;
  localparam int STS_W  = 2;
  localparam int CNT_W  = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_READ   = 3'd2,
    MODE_UPDATE = 3'd3,
    MODE_FIND   = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_BAD_POS   = 2'd3
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic              append;
    logic [KEY_W-1:0]  key_in;
    logic [PAY_W-1:0]  payload_in;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [POS_W-1:0] found_position;
    logic [KEY_W-1:0] key_out;
    logic [PAY_W-1:0] payload_out;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_UP,
    ST_INS_WR,
    ST_SHIFT_DN,
    ST_FIND,
    ST_RD_WAIT,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    RD_CNT_M1,
    RD_POS,
    RD_POS_P1,
    RD_ZERO,
    RD_IDX_M2,
    RD_IDX_P1,
    RD_IDX_P2
  } rd_sel_t;

  typedef enum logic {
    WR_ITEM,
    WR_RDATA
  } wr_sel_t;

  typedef enum logic [1:0] {
    WA_CNT,
    WA_POS,
    WA_IDX
  } wr_at_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_CNT,
    IDX_LOAD_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_item;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    wr_at_t  wr_at;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    logic    set_status;
    status_t status;
    logic    cap_entry;
    logic    cap_fpos;
    logic    out_load;
  } dp_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              append;
    logic              full;
    logic              pos_bad;
    logic              pos_last;
    logic              cnt_zero;
    logic              idx_m1_eq_pos;
    logic              idx_p1_eq_cnt;
    logic              idx_p2_eq_cnt;
    logic              key_match;
    logic              out_free;
  } dp_sts_t;

endpackage

// ----- src/ordered_array_list_engine_top.sv -----
// Positional list of up to DEPTH key/payload entries held in a memory with one
// read and one write port. Each command beat returns exactly one result beat
// carrying the status, the entry count and the empty flag. Commands are taken
// one at a time: a beat occupies the block until its result is loaded. Clear,
// update, append, failed commands and deleting the last entry go straight to
// the result and a read waits for its memory read, while an insert before a
// position, any other delete and a find walk the entries, so the entry memory,
// which moves or compares one entry per cycle through its one read and one
// write port, sets how long such a beat takes. A new command is accepted while
// the previous result still waits on out_stall.
module ordered_array_list_engine_top #(
  parameter int DEPTH        = oale_pkg::DEPTH_DEF,
  parameter int KEY_BITS     = oale_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = oale_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  oale_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output oale_pkg::out_item_t out_data
);
  import oale_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  oale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  oale_dp #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- src/oale_dp.sv -----
module oale_dp #(
  parameter int DEPTH        = oale_pkg::DEPTH_DEF,
  parameter int KEY_BITS     = oale_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = oale_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  oale_pkg::in_item_t  in_data,
  input  oale_pkg::dp_ctl_t   ctl,
  output oale_pkg::dp_sts_t   sts,
  input  logic                out_stall,
  output logic                out_valid,
  output oale_pkg::out_item_t out_data
);
  import oale_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Latched command.
  logic [MODE_W-1:0]       mode_r;
  logic [POS_W-1:0]        pos_r;
  logic                    app_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic [KEY_BITS-1:0]     key_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];
  logic [KEY_BITS-1:0]     rd_key_r;
  logic [PAYLOAD_BITS-1:0] rd_pay_r;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [KEY_BITS-1:0]     wr_key;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  status_t                 res_status_r;
  logic [POS_W-1:0]        res_fpos_r;
  logic [KEY_BITS-1:0]     res_key_r;
  logic [PAYLOAD_BITS-1:0] res_pay_r;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic [CMPW-1:0] pos_ext, cnt_ext, idx_ext;

  assign pos_ext = CMPW'(pos_r);
  assign cnt_ext = CMPW'(count_r);
  assign idx_ext = CMPW'(idx_r);

  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      mode_r <= in_data.mode;
      pos_r  <= in_data.position;
      app_r  <= in_data.append;
      key_r  <= KEY_BITS'(in_data.key_in);
      pay_r  <= PAYLOAD_BITS'(in_data.payload_in);
    end
  end

  always_comb begin
    unique case (ctl.cnt_op)
      CNT_INC: count_nxt = count_r + CW'(1);
      CNT_DEC: count_nxt = count_r - CW'(1);
      CNT_CLR: count_nxt = '0;
      default: count_nxt = count_r;
    endcase
  end

  always_comb begin
    unique case (ctl.idx_op)
      IDX_LOAD_CNT: idx_nxt = count_r;
      IDX_LOAD_POS: idx_nxt = CW'(pos_r);
      IDX_ZERO:     idx_nxt = '0;
      IDX_INC:      idx_nxt = idx_r + CW'(1);
      IDX_DEC:      idx_nxt = idx_r - CW'(1);
      default:      idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    unique case (ctl.rd_sel)
      RD_CNT_M1: rd_addr = AW'(cnt_ext - CMPW'(1));
      RD_POS:    rd_addr = AW'(pos_r);
      RD_POS_P1: rd_addr = AW'(pos_ext + CMPW'(1));
      RD_IDX_M2: rd_addr = AW'(idx_ext - CMPW'(2));
      RD_IDX_P1: rd_addr = AW'(idx_ext + CMPW'(1));
      RD_IDX_P2: rd_addr = AW'(idx_ext + CMPW'(2));
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.wr_at)
      WA_CNT:  wr_addr = AW'(count_r);
      WA_POS:  wr_addr = AW'(pos_r);
      default: wr_addr = AW'(idx_r);
    endcase
  end

  assign wr_key = (ctl.wr_sel == WR_ITEM) ? key_r : rd_key_r;
  assign wr_pay = (ctl.wr_sel == WR_ITEM) ? pay_r : rd_pay_r;

  // Single write port and single registered read port; a shift reads one
  // entry ahead of the one it writes.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    if (ctl.rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_pay_r <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      res_status_r <= STS_OK;
      res_fpos_r   <= '0;
      res_key_r    <= '0;
      res_pay_r    <= '0;
    end else begin
      if (ctl.set_status) begin
        res_status_r <= ctl.status;
      end
      if (ctl.cap_entry) begin
        res_key_r <= rd_key_r;
        res_pay_r <= rd_pay_r;
      end
      if (ctl.cap_fpos) begin
        res_fpos_r <= POS_W'(idx_r);
      end
    end
  end

  always_comb begin
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.status         <= res_status_r;
      out_data_r.found_position <= res_fpos_r;
      out_data_r.key_out        <= KEY_W'(res_key_r);
      out_data_r.payload_out    <= PAY_W'(res_pay_r);
      out_data_r.entry_count    <= CNT_W'(count_r);
      out_data_r.is_empty       <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.mode          = mode_r;
    sts.append        = app_r;
    sts.full          = (count_r == CW'(DEPTH));
    sts.pos_bad       = (pos_ext >= cnt_ext);
    sts.pos_last      = ((pos_ext + CMPW'(1)) == cnt_ext);
    sts.cnt_zero      = (count_r == '0);
    sts.idx_m1_eq_pos = (idx_ext == (pos_ext + CMPW'(1)));
    sts.idx_p1_eq_cnt = ((idx_ext + CMPW'(1)) == cnt_ext);
    sts.idx_p2_eq_cnt = ((idx_ext + CMPW'(2)) == cnt_ext);
    sts.key_match     = (rd_key_r == key_r);
    sts.out_free      = !out_valid_r || !out_stall;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond list depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwrites a beat still waiting");

  a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> (CMPW'(wr_addr) <= cnt_ext))
    else $error("write beyond the end of the list");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cnt_op == CNT_INC) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("count did not advance on insert");

endmodule

// ----- src/oale_ctrl.sv -----
module oale_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  oale_pkg::dp_sts_t sts,
  output oale_pkg::dp_ctl_t ctl
);
  import oale_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    ctl.latch_item = 1'b0;
    ctl.rd_en      = 1'b0;
    ctl.rd_sel     = RD_ZERO;
    ctl.wr_en      = 1'b0;
    ctl.wr_sel     = WR_ITEM;
    ctl.wr_at      = WA_IDX;
    ctl.idx_op     = IDX_HOLD;
    ctl.cnt_op     = CNT_HOLD;
    ctl.set_status = 1'b0;
    ctl.status     = STS_OK;
    ctl.cap_entry  = 1'b0;
    ctl.cap_fpos   = 1'b0;
    ctl.out_load   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        ctl.latch_item = in_valid;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_nxt = ST_RESP;
        unique case (sts.mode)
          MODE_INSERT: begin
            priority if (sts.full) begin
              ctl.set_status = 1'b1;
              ctl.status     = STS_FULL;
            end else if (sts.append) begin
              ctl.wr_en  = 1'b1;
              ctl.wr_at  = WA_CNT;
              ctl.cnt_op = CNT_INC;
            end else if (sts.pos_bad) begin
              ctl.set_status = 1'b1;
              ctl.status     = STS_BAD_POS;
            end else begin
              // Walk down from the last entry, moving each one up a place.
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_CNT_M1;
              ctl.idx_op = IDX_LOAD_CNT;
              state_nxt  = ST_SHIFT_UP;
            end
          end
          MODE_DELETE: begin
            priority if (sts.pos_bad) begin
              ctl.set_status = 1'b1;
              ctl.status     = STS_BAD_POS;
            end else if (sts.pos_last) begin
              ctl.cnt_op = CNT_DEC;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_POS_P1;
              ctl.idx_op = IDX_LOAD_POS;
              state_nxt  = ST_SHIFT_DN;
            end
          end
          MODE_READ: begin
            if (sts.pos_bad) begin
              ctl.set_status = 1'b1;
              ctl.status     = STS_BAD_POS;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_POS;
              state_nxt  = ST_RD_WAIT;
            end
          end
          MODE_UPDATE: begin
            if (sts.pos_bad) begin
              ctl.set_status = 1'b1;
              ctl.status     = STS_BAD_POS;
            end else begin
              ctl.wr_en = 1'b1;
              ctl.wr_at = WA_POS;
            end
          end
          MODE_FIND: begin
            if (sts.cnt_zero) begin
              ctl.set_status = 1'b1;
              ctl.status     = STS_NOT_FOUND;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RD_ZERO;
              ctl.idx_op = IDX_ZERO;
              state_nxt  = ST_FIND;
            end
          end
          MODE_CLEAR: begin
            ctl.cnt_op = CNT_CLR;
          end
          default: begin
            ctl.set_status = 1'b1;
            ctl.status     = STS_BAD_POS;
          end
        endcase
      end

      ST_SHIFT_UP: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_RDATA;
        ctl.wr_at  = WA_IDX;
        if (sts.idx_m1_eq_pos) begin
          state_nxt = ST_INS_WR;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_M2;
          ctl.idx_op = IDX_DEC;
        end
      end

      ST_INS_WR: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_at  = WA_POS;
        ctl.cnt_op = CNT_INC;
        state_nxt  = ST_RESP;
      end

      ST_SHIFT_DN: begin
        ctl.wr_en  = 1'b1;
        ctl.wr_sel = WR_RDATA;
        ctl.wr_at  = WA_IDX;
        if (sts.idx_p2_eq_cnt) begin
          ctl.cnt_op = CNT_DEC;
          state_nxt  = ST_RESP;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_P2;
          ctl.idx_op = IDX_INC;
        end
      end

      ST_FIND: begin
        priority if (sts.key_match) begin
          ctl.cap_entry = 1'b1;
          ctl.cap_fpos  = 1'b1;
          state_nxt     = ST_RESP;
        end else if (sts.idx_p1_eq_cnt) begin
          ctl.set_status = 1'b1;
          ctl.status     = STS_NOT_FOUND;
          state_nxt      = ST_RESP;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX_P1;
          ctl.idx_op = IDX_INC;
        end
      end

      ST_RD_WAIT: begin
        ctl.cap_entry = 1'b1;
        state_nxt     = ST_RESP;
      end

      ST_RESP: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DECODE))
    else $error("accepted beat not decoded");

  a_shift_up_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT_UP || state_r == ST_INS_WR) |-> (sts.mode == MODE_INSERT))
    else $error("upward shift outside an insert");

  a_find_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND) |-> (sts.mode == MODE_FIND && !sts.cnt_zero))
    else $error("search running without a find on a filled list");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import oale_pkg::*;

  localparam int LIST_DEPTH     = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int PAUSE_EVERY    = 400;
  localparam int KEY_POOL_SIZE  = 12;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  // Mode codes that the block does not define; both must be refused.
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  typedef enum {SEQ_GROW, SEQ_SHRINK, SEQ_MIXED, SEQ_NOISE} seq_kind_t;
  typedef enum {STALL_NONE, STALL_COIN, STALL_LONG, STALL_TOGGLE} stall_style_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  ordered_array_list_engine_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the list contents.
  logic [KEY_W-1:0] shadow_keys [LIST_DEPTH];
  logic [PAY_W-1:0] shadow_pays [LIST_DEPTH];
  int               list_len = 0;
  int               peak_len = 0;

  in_item_t  pending_cmds [$];
  out_item_t pending_results [$];
  out_item_t due_result;
  out_item_t seen_result;

  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
  int mode_hits [8];
  int status_hits [4];
  int fault_count = 0;
  int gap_left = 0;
  int burst_left = 1;
  int pattern_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  stall_style_t stall_style = STALL_NONE;

  // Applies one command to the shadow list and returns the result beat it earns.
  function automatic out_item_t list_apply(in_item_t cmd);
    out_item_t res;
    int pos;
    int i;
    res = '0;
    res.status = STS_OK;
    pos = int'(cmd.position);
    case (cmd.mode)
      MODE_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = STS_FULL;
        end else if (!cmd.append && pos >= list_len) begin
          res.status = STS_BAD_POS;
        end else begin
          if (cmd.append) pos = list_len;
          for (i = list_len; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
          end
          shadow_keys[pos] = cmd.key_in;
          shadow_pays[pos] = cmd.payload_in;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (pos >= list_len) begin
          res.status = STS_BAD_POS;
        end else begin
          for (i = pos; i + 1 < list_len; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pays[i] = shadow_pays[i+1];
          end
          list_len--;
        end
      end
      MODE_READ: begin
        if (pos >= list_len) begin
          res.status = STS_BAD_POS;
        end else begin
          res.key_out = shadow_keys[pos];
          res.payload_out = shadow_pays[pos];
        end
      end
      MODE_UPDATE: begin
        if (pos >= list_len) begin
          res.status = STS_BAD_POS;
        end else begin
          shadow_keys[pos] = cmd.key_in;
          shadow_pays[pos] = cmd.payload_in;
        end
      end
      MODE_FIND: begin
        res.status = STS_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (res.status == STS_NOT_FOUND && shadow_keys[i] == cmd.key_in) begin
            res.status = STS_OK;
            res.found_position = POS_W'(i);
            res.key_out = shadow_keys[i];
            res.payload_out = shadow_pays[i];
          end
        end
      end
      MODE_CLEAR: list_len = 0;
      default: res.status = STS_BAD_POS;
    endcase
    res.entry_count = CNT_W'(list_len);
    res.is_empty = (list_len == 0);
    if (list_len > peak_len) peak_len = list_len;
    mode_hits[cmd.mode]++;
    status_hits[res.status]++;
    return res;
  endfunction

  // Driver: presents queued command beats in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) pending_results.push_back(list_apply(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_data <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 50);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(0, 2);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  // Monitor: checks each result beat and drives the receiver's stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_result = out_data;
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no command outstanding");
          fault_count++;
        end else begin
          due_result = pending_results.pop_front();
          compare_field("status", 64'(due_result.status), 64'(seen_result.status));
          compare_field("found_position", 64'(due_result.found_position),
                        64'(seen_result.found_position));
          compare_field("key_out", 64'(due_result.key_out), 64'(seen_result.key_out));
          compare_field("payload_out", 64'(due_result.payload_out),
                        64'(seen_result.payload_out));
          compare_field("entry_count", 64'(due_result.entry_count),
                        64'(seen_result.entry_count));
          compare_field("is_empty", 64'(due_result.is_empty),
                        64'(seen_result.is_empty));
        end
      end
      if (pattern_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(50, 400);
      end else begin
        pattern_left--;
      end
      case (stall_style)
        STALL_NONE: out_stall <= 1'b0;
        STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
        STALL_LONG: begin
          if (hold_left == 0) begin
            out_stall <= ~out_stall;
            hold_left = $urandom_range(1, 40);
          end else begin
            hold_left--;
          end
        end
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_cmd(input logic [MODE_W-1:0] mode, input int pos, input bit app,
                           input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] pay);
    in_item_t cmd;
    cmd.mode = mode;
    cmd.position = POS_W'(pos);
    cmd.append = app;
    cmd.key_in = key;
    cmd.payload_in = pay;
    while (pending_cmds.size() >= 2) @(negedge clk);
    pending_cmds.push_back(cmd);
  endtask

  // Mostly positions inside the list, sometimes anywhere in the field's range.
  function automatic int pick_position();
    if (list_len == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 31);
    return $urandom_range(0, list_len - 1);
  endfunction

  // Keys come mostly from a small pool so that duplicates and find hits are common.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random_cmd(input seq_kind_t kind);
    logic [MODE_W-1:0] mode;
    int roll;
    mode = MODE_INSERT;
    roll = $urandom_range(0, 99);
    case (kind)
      SEQ_GROW: mode = MODE_INSERT;
      SEQ_SHRINK: mode = MODE_DELETE;
      SEQ_MIXED: begin
        if (roll < 25) mode = MODE_INSERT;
        else if (roll < 45) mode = MODE_DELETE;
        else if (roll < 63) mode = MODE_READ;
        else if (roll < 80) mode = MODE_UPDATE;
        else if (roll < 95) mode = MODE_FIND;
        else if (roll < 97) mode = MODE_CLEAR;
        else mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
      end
      default: begin
        queue_cmd(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 31),
                  1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom);
        return;
      end
    endcase
    queue_cmd(mode, pick_position(), 1'($urandom_range(0, 1)), pick_key(), $urandom);
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic drain_list();
    while (pending_cmds.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int issued;
    int run_len;
    int next_pause;
    int k;
    int roll;
    seq_kind_t kind;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (k = 2; k < KEY_POOL_SIZE; k++) key_pool[k] = {$urandom, $urandom};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty list: every positional command is refused and find misses.
    queue_cmd(MODE_FIND, 0, 1'b0, '0, '0);
    queue_cmd(MODE_READ, 0, 1'b0, '0, '0);
    queue_cmd(MODE_DELETE, 31, 1'b1, '1, '1);
    queue_cmd(MODE_UPDATE, 0, 1'b0, '1, '1);
    queue_cmd(MODE_INSERT, 0, 1'b0, key_pool[2], 32'h1);
    queue_cmd(MODE_INSERT, 31, 1'b1, '1, '1);
    queue_cmd(MODE_INSERT, 0, 1'b1, '0, '0);
    queue_cmd(MODE_INSERT, 0, 1'b0, key_pool[2], 32'hA5A5_5A5A);
    queue_cmd(MODE_INSERT, 2, 1'b0, '1, 32'h0000_FFFF);
    // Position equal to the count is out of range unless appending.
    queue_cmd(MODE_INSERT, 4, 1'b0, key_pool[3], 32'h1234_5678);
    queue_cmd(MODE_READ, 0, 1'b0, '0, '0);
    queue_cmd(MODE_READ, 3, 1'b1, '1, '1);
    queue_cmd(MODE_READ, 31, 1'b0, '0, '0);
    queue_cmd(MODE_UPDATE, 2, 1'b0, key_pool[4], 32'hFFFF_0000);
    queue_cmd(MODE_FIND, 0, 1'b0, '1, '0);
    queue_cmd(MODE_FIND, 31, 1'b1, '0, '1);
    queue_cmd(MODE_FIND, 0, 1'b0, key_pool[5], '0);
    queue_cmd(MODE_DELETE, 0, 1'b0, '0, '0);
    queue_cmd(MODE_DELETE, 2, 1'b0, '0, '0);
    queue_cmd(MODE_DELETE, 5, 1'b0, '0, '0);
    queue_cmd(MODE_SPARE_A, 0, 1'b0, '1, '1);
    queue_cmd(MODE_SPARE_B, 1, 1'b1, '0, '0);
    queue_cmd(MODE_CLEAR, 17, 1'b1, '1, '1);
    queue_cmd(MODE_FIND, 0, 1'b0, '1, '0);
    queue_cmd(MODE_READ, 0, 1'b0, '0, '0);
    drain_list();

    // Random part: open with a run long enough to fill the list and overflow it.
    issued = 0;
    next_pause = PAUSE_EVERY;
    kind = SEQ_GROW;
    run_len = LIST_DEPTH + 6;
    while (issued < RANDOM_ITEMS) begin
      for (k = 0; k < run_len; k++) queue_random_cmd(kind);
      issued += run_len;
      if (issued >= next_pause) begin
        drain_list();
        next_pause += PAUSE_EVERY;
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        kind = SEQ_GROW;
        run_len = $urandom_range(4, 40);
      end else if (roll < 55) begin
        kind = SEQ_SHRINK;
        run_len = $urandom_range(3, 35);
      end else if (roll < 90) begin
        kind = SEQ_MIXED;
        run_len = $urandom_range(5, 30);
      end else begin
        kind = SEQ_NOISE;
        run_len = $urandom_range(2, 10);
      end
    end

    while (pending_cmds.size() != 0 || in_valid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Commands: %0d insert, %0d delete, %0d read, %0d update, %0d find, %0d clear",
             mode_hits[MODE_INSERT], mode_hits[MODE_DELETE], mode_hits[MODE_READ],
             mode_hits[MODE_UPDATE], mode_hits[MODE_FIND], mode_hits[MODE_CLEAR]);
    $display("Unused codes: %0d; outcomes: %0d ok, %0d full, %0d not found, %0d bad position",
             mode_hits[MODE_SPARE_A] + mode_hits[MODE_SPARE_B],
             status_hits[STS_OK], status_hits[STS_FULL], status_hits[STS_NOT_FOUND],
             status_hits[STS_BAD_POS]);
    $display("Peak list length %0d", peak_len);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- ordered_array_list_engine_top.f -----
src/oale_pkg.sv
src/oale_dp.sv
src/oale_ctrl.sv
src/ordered_array_list_engine_top.sv
tb/testbench.sv
